/* design/bq_pkg.sv */
// ----------------------------------------------------------------------------
// bq_pkg
// shared types, widths and register indexes of the biquad filter unit
// ----------------------------------------------------------------------------
`default_nettype none

package bq_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 32;
  localparam int COEF_FRAC    = COEF_WIDTH - 4;
  localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int DELAY_WIDTH  = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_WIDTH    = DELAY_WIDTH + 2;
  localparam int NUM_REGS     = 5;
  localparam int CFG_IDX_W    = 3;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;
  typedef logic signed [DELAY_WIDTH-1:0]  delay_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;
  typedef logic [CFG_IDX_W-1:0]           reg_idx_t;

  // register indexes
  localparam reg_idx_t REG_B0 = reg_idx_t'(0);
  localparam reg_idx_t REG_B1 = reg_idx_t'(1);
  localparam reg_idx_t REG_B2 = reg_idx_t'(2);
  localparam reg_idx_t REG_A1 = reg_idx_t'(3);
  localparam reg_idx_t REG_A2 = reg_idx_t'(4);

  // b0 resets to unity gain
  localparam coef_t COEF_ONE = coef_t'(64'sd1 <<< COEF_FRAC);

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam delay_t  DELAY_MAX  = {1'b0, {(DELAY_WIDTH-1){1'b1}}};
  localparam delay_t  DELAY_MIN  = {1'b1, {(DELAY_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    ADD_ZERO,
    ADD_D1,
    ADD_D2,
    ADD_ACC
  } addend_sel_e;

  typedef struct packed {
    logic        mul_en;    // load product register
    logic        mul_src_y; // multiply output sample instead of input sample
    logic        acc_en;    // load accumulator
    logic        sub;       // addend minus product
    addend_sel_e addend;
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* design/biquad_iir_filter_unit.sv */
// ----------------------------------------------------------------------------
// biquad_iir_filter_unit
// second-order iir filter, transposed direct form ii, fixed point
// ----------------------------------------------------------------------------
// One Q1.23 sample in, one Q1.23 sample out. A sample transfer is taken only
// while the unit is idle; the five products run through a single 24x32
// multiplier under a small sequencer, so one sample occupies the unit through
// an acceptance step, seven multiply/accumulate steps and a step that hands
// the result to the output register, staying longer only while the previous
// result still waits on a stalled output. Coefficients b0, b1, b2, a1, a2
// (already divided by a0) are Q4.28 registers at indexes 0 to 4; writes to
// other indexes are dropped. They should be written only
// while no sample is in flight. After reset b0 is 1.0, the rest are 0, and
// both 56-bit delay registers are cleared. The output is rounded half up and
// saturated to 24 bits with clipped_o flagging it; the saturated value is
// what feeds back. Delay updates saturate silently.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_iir_filter_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration writes
  input  wire logic              cfg_we_i,
  input  wire bq_pkg::reg_idx_t  cfg_idx_i,
  input  wire bq_pkg::coef_t     cfg_data_i,
  // sample input
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire bq_pkg::sample_t   sample_in_i,
  // sample output
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output bq_pkg::sample_t        sample_out_o,
  output logic                   clipped_o
);
  import bq_pkg::*;

  // sequencer steps
  //   S_B0: prod = x*b0
  //   S_Y0: acc = prod + d1, prod = x*b1
  //   S_Y1: y from acc, acc = d2 + prod
  //   S_A1: prod = y*a1
  //   S_D1: d1 = acc - prod, prod = x*b2
  //   S_A2: acc = prod, prod = y*a2
  //   S_D2: d2 = acc - prod
  //   S_OUT: hand y to the output register once it is free
  typedef enum logic [3:0] {
    S_IDLE,
    S_B0,
    S_Y0,
    S_Y1,
    S_A1,
    S_D1,
    S_A2,
    S_D2,
    S_OUT
  } state_e;

  state_e    state_q;
  coef_t     coef_q [NUM_REGS];
  sample_t   x_q;
  sample_t   y_q;
  logic      clip_q;
  delay_t    d1_q;
  delay_t    d2_q;
  logic      out_valid_q;
  sample_t   out_sample_q;
  logic      out_clip_q;

  mac_ctrl_t ctrl;
  reg_idx_t  coef_sel;
  coef_t     coef_mux;
  acc_t      sum;
  acc_t      acc;

  // rounding and output saturation
  acc_t      acc_rnd;
  acc_t      acc_shr;
  logic      y_ovf;
  sample_t   y_sat;

  // delay saturation of the adder result
  logic      d_ovf;
  delay_t    d_sat;

  logic      in_xfer;
  logic      out_free;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign clipped_o    = out_clip_q;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[REG_B0] <= COEF_ONE;
      coef_q[REG_B1] <= '0;
      coef_q[REG_B2] <= '0;
      coef_q[REG_A1] <= '0;
      coef_q[REG_A2] <= '0;
    end else if (cfg_we_i && (cfg_idx_i < reg_idx_t'(NUM_REGS))) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // per-step control of the shared unit
  always_comb begin
    ctrl     = '{mul_en: 1'b0, mul_src_y: 1'b0, acc_en: 1'b0, sub: 1'b0,
                 addend: ADD_ZERO};
    coef_sel = REG_B0;
    case (state_q)
      S_B0: begin
        ctrl.mul_en = 1'b1;
        coef_sel    = REG_B0;
      end
      S_Y0: begin
        ctrl.mul_en = 1'b1;
        coef_sel    = REG_B1;
        ctrl.acc_en = 1'b1;
        ctrl.addend = ADD_D1;
      end
      S_Y1: begin
        ctrl.acc_en = 1'b1;
        ctrl.addend = ADD_D2;
      end
      S_A1: begin
        ctrl.mul_en    = 1'b1;
        ctrl.mul_src_y = 1'b1;
        coef_sel       = REG_A1;
      end
      S_D1: begin
        ctrl.mul_en = 1'b1;
        coef_sel    = REG_B2;
        ctrl.sub    = 1'b1;
        ctrl.addend = ADD_ACC;
      end
      S_A2: begin
        ctrl.mul_en    = 1'b1;
        ctrl.mul_src_y = 1'b1;
        coef_sel       = REG_A2;
        ctrl.acc_en    = 1'b1;
        ctrl.addend    = ADD_ZERO;
      end
      S_D2: begin
        ctrl.sub    = 1'b1;
        ctrl.addend = ADD_ACC;
      end
      default: begin
        ctrl.addend = ADD_ZERO;
      end
    endcase
  end

  assign coef_mux = coef_q[coef_sel];

  bq_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .x_i    (x_q),
    .y_i    (y_q),
    .coef_i (coef_mux),
    .d1_i   (d1_q),
    .d2_i   (d2_q),
    .sum_o  (sum),
    .acc_o  (acc)
  );

  // round half up at the q1.23 point, then clamp to the sample range
  assign acc_rnd = acc + acc_t'(64'sd1 <<< (COEF_FRAC - 1));
  assign acc_shr = acc_rnd >>> COEF_FRAC;
  assign y_ovf   = !((&acc_shr[ACC_WIDTH-1:SAMPLE_WIDTH-1]) ||
                     !(|acc_shr[ACC_WIDTH-1:SAMPLE_WIDTH-1]));
  assign y_sat   = y_ovf ? (acc_shr[ACC_WIDTH-1] ? SAMPLE_MIN : SAMPLE_MAX)
                         : acc_shr[SAMPLE_WIDTH-1:0];

  // clamp the new delay value to 56 bits
  assign d_ovf = !((&sum[ACC_WIDTH-1:DELAY_WIDTH-1]) ||
                   !(|sum[ACC_WIDTH-1:DELAY_WIDTH-1]));
  assign d_sat = d_ovf ? (sum[ACC_WIDTH-1] ? DELAY_MIN : DELAY_MAX)
                       : sum[DELAY_WIDTH-1:0];

  // sequencer, delay line and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      d1_q         <= '0;
      d2_q         <= '0;
      out_valid_q  <= 1'b0;
      x_q          <= '0;
      y_q          <= '0;
      clip_q       <= 1'b0;
      out_sample_q <= '0;
      out_clip_q   <= 1'b0;
    end else begin
      // output register empties on a transfer, unless a new result moves in
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            x_q     <= sample_in_i;
            state_q <= S_B0;
          end
        end
        S_B0: state_q <= S_Y0;
        S_Y0: state_q <= S_Y1;
        S_Y1: begin
          y_q     <= y_sat;
          clip_q  <= y_ovf;
          state_q <= S_A1;
        end
        S_A1: state_q <= S_D1;
        S_D1: begin
          d1_q    <= d_sat;
          state_q <= S_A2;
        end
        S_A2: state_q <= S_D2;
        S_D2: begin
          d2_q    <= d_sat;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_sample_q <= y_q;
            out_clip_q   <= clip_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // a transfer in always starts the multiply sequence
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_B0))
    else $error("sample transfer did not start the sequence");

  // a clipped result is one of the two range limits
  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |->
      (sample_out_o == SAMPLE_MAX) || (sample_out_o == SAMPLE_MIN))
    else $error("clipped flag without a saturated sample");

  // first delay only changes in its update step
  a_d1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_D1) |=> (d1_q == $past(d1_q)))
    else $error("first delay changed outside its update step");

  // a free output slot is filled right after the last step
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_OUT) && !out_valid_o) |=> (out_valid_o && (state_q == S_IDLE)))
    else $error("finished sample not moved to the output register");

endmodule

`default_nettype wire

/* design/bq_mac.sv */
// ----------------------------------------------------------------------------
// bq_mac
// shared multiplier with registered product, and add/subtract accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module bq_mac (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bq_pkg::mac_ctrl_t ctrl_i,
  input  wire bq_pkg::sample_t  x_i,
  input  wire bq_pkg::sample_t  y_i,
  input  wire bq_pkg::coef_t    coef_i,
  input  wire bq_pkg::delay_t   d1_i,
  input  wire bq_pkg::delay_t   d2_i,
  output bq_pkg::acc_t          sum_o,
  output bq_pkg::acc_t          acc_o
);
  import bq_pkg::*;

  sample_t mul_a;
  prod_t   prod_d;
  prod_t   prod_q;
  acc_t    addend;
  acc_t    prod_ext;
  acc_t    acc_q;

  assign mul_a  = ctrl_i.mul_src_y ? y_i : x_i;
  assign prod_d = prod_t'(mul_a) * prod_t'(coef_i);

  always_comb begin
    case (ctrl_i.addend)
      ADD_ZERO: addend = '0;
      ADD_D1:   addend = acc_t'(d1_i);
      ADD_D2:   addend = acc_t'(d2_i);
      ADD_ACC:  addend = acc_q;
      default:  addend = '0;
    endcase
  end

  assign prod_ext = acc_t'(prod_q);
  assign sum_o    = ctrl_i.sub ? (addend - prod_ext) : (addend + prod_ext);
  assign acc_o    = acc_q;

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      if (ctrl_i.mul_en) begin
        prod_q <= prod_d;
      end
      if (ctrl_i.acc_en) begin
        acc_q <= sum_o;
      end
    end
  end

endmodule

`default_nettype wire
